// File: rtl/core/swm_pkg.sv
// Package with the shared constants, types and codes of the sliding window maximum filter.
`timescale 1ns / 1ps

package swm_pkg;

    localparam int WINDOW_MAX_DEFAULT = 64;
    localparam int SAMPLE_W           = 32;
    localparam int CFG_W              = 7;
    localparam int APB_DATA_W         = 32;
    localparam int APB_ADDR_W         = 3;
    localparam int REG_IDX_W          = 1;

    localparam logic [CFG_W-1:0]     WINDOW_SIZE_RESET = 7'd3;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_SIZE   = 1'b0;

    // Starting value of a scan: the most negative sample.
    localparam logic signed [SAMPLE_W-1:0] BEST_INIT = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // Scan token that walks down the cell row, one cell per cycle.
    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] best;
    } tok_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT
    } state_t;

endpackage

// File: rtl/core/swm_cell.sv
// One cell of the window row: holds one sample and updates the passing scan token.
`timescale 1ns / 1ps

module swm_cell #(
    parameter int KW  = 7,
    parameter int IDX = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                shift_en,
    input  logic signed [swm_pkg::SAMPLE_W-1:0] sample_in,
    output logic signed [swm_pkg::SAMPLE_W-1:0] sample_out,
    input  logic [KW-1:0]                       k,
    input  swm_pkg::tok_t                       tok_in,
    output swm_pkg::tok_t                       tok_out
);

    logic signed [swm_pkg::SAMPLE_W-1:0] sample_reg;
    swm_pkg::tok_t                       tok_reg;
    swm_pkg::tok_t                       tok_next;
    logic                                active;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            sample_reg <= sample_in;
        end
    end

    // A cell takes part in the scan only if its sample lies inside the window.
    assign active = (KW'(IDX) < k);

    always_comb
    begin
        tok_next.valid = tok_in.valid;
        tok_next.best  = tok_in.best;
        if (tok_in.valid && active && (sample_reg > tok_in.best))
        begin
            tok_next.best = sample_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign sample_out = sample_reg;
    assign tok_out    = tok_reg;

endmodule

// File: rtl/core/sliding_window_max.sv
// Top level of the sliding window maximum filter: cell row, control and register port.
//
//  Channel  | Signals                              | Contents
//  ---------+--------------------------------------+-------------------------------
//  input    | s_tvalid s_tready s_tdata s_tuser    | sample, start_sequence
//  output   | m_tvalid m_tready m_tdata            | window_max
//  config   | psel penable pwrite paddr pwdata ... | window_size at byte address 0
//
// A sample that yields no result is taken and the block stays ready for the next one. A sample
// that yields a result starts a scan: a scan token walks the row of WINDOW_MAX cells, one cell per cycle.
// A finished result sits in the output register while the next sample is taken.
// If that register is still full when a scan ends, the block waits for it to drain.
// After reset the block is ready at once, with window_size at 3.
`timescale 1ns / 1ps

module sliding_window_max #(
    parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [swm_pkg::SAMPLE_W-1:0]      s_tdata,   // [31:0] sample
    input  logic                              s_tuser,   // [0] start_sequence
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [swm_pkg::SAMPLE_W-1:0]      m_tdata,   // [31:0] window_max
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [swm_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [swm_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [swm_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int KW   = $clog2(WINDOW_MAX + 1);
    localparam int CMPW = (KW > swm_pkg::CFG_W) ? KW : swm_pkg::CFG_W;

    swm_pkg::state_t state_reg;
    swm_pkg::state_t state_next;

    logic [swm_pkg::CFG_W-1:0]           ws_reg;
    logic [KW-1:0]                       k;
    logic [KW-1:0]                       fill_reg;
    logic [KW-1:0]                       fill_base;
    logic [KW-1:0]                       fill_next;
    logic                                emit;
    logic                                in_acc;
    logic                                out_free;
    logic                                launch_reg;
    logic                                launch_next;
    logic                                load_from_tail;
    logic                                load_from_hold;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic signed [swm_pkg::SAMPLE_W-1:0] out_data_reg;
    logic signed [swm_pkg::SAMPLE_W-1:0] hold_reg;
    logic                                cfg_wr;
    logic [swm_pkg::REG_IDX_W-1:0]       reg_idx;

    logic signed [swm_pkg::SAMPLE_W-1:0] sample_chain [0:WINDOW_MAX];
    swm_pkg::tok_t                       tok_chain    [0:WINDOW_MAX];

    // Register port.
    assign pready  = 1'b1;
    assign reg_idx = paddr[swm_pkg::APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready
                     && (reg_idx == swm_pkg::REG_WINDOW_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg <= swm_pkg::WINDOW_SIZE_RESET;
        end
        else if (cfg_wr)
        begin
            ws_reg <= pwdata[swm_pkg::CFG_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == swm_pkg::REG_WINDOW_SIZE)
        begin
            prdata = swm_pkg::APB_DATA_W'(ws_reg);
        end
    end

    // Effective window length, clamped to 1..WINDOW_MAX.
    always_comb
    begin
        if (ws_reg == '0)
        begin
            k = KW'(1);
        end
        else if (CMPW'(ws_reg) > CMPW'(WINDOW_MAX))
        begin
            k = KW'(WINDOW_MAX);
        end
        else
        begin
            k = KW'(ws_reg);
        end
    end

    assign in_acc    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign fill_base = s_tuser ? '0 : fill_reg;
    assign fill_next = (fill_base < KW'(WINDOW_MAX)) ? KW'(fill_base + KW'(1)) : fill_base;
    assign emit      = (fill_next >= k);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (in_acc)
        begin
            fill_reg <= fill_next;
        end
    end

    // Cell row.
    assign sample_chain[0]    = $signed(s_tdata);
    assign tok_chain[0].valid = launch_reg;
    assign tok_chain[0].best  = swm_pkg::BEST_INIT;

    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        swm_cell #(
            .KW  (KW),
            .IDX (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift_en   (in_acc),
            .sample_in  (sample_chain[i]),
            .sample_out (sample_chain[i+1]),
            .k          (k),
            .tok_in     (tok_chain[i]),
            .tok_out    (tok_chain[i+1])
        );
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            swm_pkg::ST_IDLE:
            begin
                if (in_acc && emit)
                begin
                    state_next = swm_pkg::ST_SCAN;
                end
            end
            swm_pkg::ST_SCAN:
            begin
                if (tok_chain[WINDOW_MAX].valid)
                begin
                    state_next = out_free ? swm_pkg::ST_IDLE : swm_pkg::ST_WAIT;
                end
            end
            swm_pkg::ST_WAIT:
            begin
                if (out_free)
                begin
                    state_next = swm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swm_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the state machine.
    always_comb
    begin
        s_tready       = 1'b0;
        launch_next    = 1'b0;
        load_from_tail = 1'b0;
        load_from_hold = 1'b0;
        unique case (state_reg)
            swm_pkg::ST_IDLE:
            begin
                s_tready    = 1'b1;
                launch_next = s_tvalid && emit;
            end
            swm_pkg::ST_SCAN:
            begin
                load_from_tail = tok_chain[WINDOW_MAX].valid && out_free;
            end
            swm_pkg::ST_WAIT:
            begin
                load_from_hold = out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= swm_pkg::ST_IDLE;
            launch_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == swm_pkg::ST_SCAN) && tok_chain[WINDOW_MAX].valid)
        begin
            hold_reg <= tok_chain[WINDOW_MAX].best;
        end
    end

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_from_tail || load_from_hold)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_from_tail)
        begin
            out_data_reg <= tok_chain[WINDOW_MAX].best;
        end
        else if (load_from_hold)
        begin
            out_data_reg <= hold_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A new transaction is taken only while no scan is in flight.
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (state_reg == swm_pkg::ST_IDLE))
        else $error("input taken while a scan is in flight");

    // The token leaves the row only during a scan.
    a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tok_chain[WINDOW_MAX].valid |-> (state_reg == swm_pkg::ST_SCAN))
        else $error("scan token left the row outside a scan");

    // Waiting only happens while the output register is full.
    a_wait_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == swm_pkg::ST_WAIT) |-> out_valid_reg)
        else $error("waiting with an empty output register");

    // A start flag restarts the fill count at one.
    a_start_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && s_tuser) |=> (fill_reg == KW'(1)))
        else $error("fill count not restarted by start flag");

    // The fill count never exceeds the row length.
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= KW'(WINDOW_MAX))
        else $error("fill count beyond row length");

endmodule
